// ===== rtl/cbn_pkg.sv =====
package cbn_pkg;

  localparam int unsigned MAX_EXTENT = 32;

  localparam int unsigned SITE_W = 20;
  localparam int unsigned HX_W   = 5;
  localparam int unsigned EXT_W  = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_EXTENT_X = 2'd0,
    REG_EXTENT_Y      = 2'd1,
    REG_EXTENT_Z      = 2'd2,
    REG_EXTENT_T      = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIR_X = 2'd0,
    DIR_Y = 2'd1,
    DIR_Z = 2'd2,
    DIR_T = 2'd3
  } dir_t;

  typedef struct packed {
    logic [SITE_W-1:0] site_index;
    logic [1:0]        direction;
    logic              forward;
  } in_t;

  typedef struct packed {
    logic [SITE_W-1:0] neighbor_site;
    logic              out_of_range;
  } out_t;

  localparam int unsigned S_D2    = 1;
  localparam int unsigned S_HV    = 2;
  localparam int unsigned S_SPLIT = 3;
  localparam int unsigned S_T0    = 4;
  localparam int unsigned S_Z0    = 9;
  localparam int unsigned S_Y0    = 14;
  localparam int unsigned S_STEP  = 19;
  localparam int unsigned S_M1    = 20;
  localparam int unsigned S_M2    = 21;
  localparam int unsigned S_M3    = 22;
  localparam int unsigned S_OUT   = 23;
  localparam int unsigned NUM_STAGES = 24;

endpackage

// ===== rtl/checkerboard_lattice_neighbor_index.sv =====
// Neighbor index on a periodic 4D lattice in even-odd order.
// Input channel in_valid/in_ready/in_data carries a site index, an axis and a
// step sign; the output channel out_valid/out_ready/out_data returns the
// neighbor's index, or zero with out_of_range set when the site lies outside
// the lattice or the geometry registers are unusable.
// Geometry is written on cfg_valid/cfg_index/cfg_data (cfg_ready is always
// high); write it only while no item is in flight.
// One item is accepted every cycle unless the receiver stalls with a result
// waiting. The pipeline holds the three extent products, three 5-bit restoring
// divisions (one quotient bit per stage), the step, and a three-multiply
// Horner rebuild of the index.
// Reset empties the pipeline and loads half_extent_x 2 and extents 4, 4, 4.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready drops; nothing is lost or repeated.
module checkerboard_lattice_neighbor_index (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  cbn_pkg::in_t                          in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output cbn_pkg::out_t                         out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [cbn_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [cbn_pkg::CFG_DATA_W-1:0]        cfg_data
);

  typedef struct packed {
    logic [19:0] site;
    logic [1:0]  dir;
    logic        fwd;
    logic        bad;
    logic [10:0] d1;
    logic [16:0] d2;
    logic [22:0] hv;
    logic        oor;
    logic        par;
    logic [19:0] rem;
    logic [5:0]  ct;
    logic [5:0]  cz;
    logic [5:0]  cy;
    logic [5:0]  cx;
    logic [24:0] m;
  } pipe_t;

  localparam int unsigned NS = cbn_pkg::NUM_STAGES;

  logic [4:0] hx_r;
  logic [5:0] ey_r, ez_r, et_r;

  pipe_t st_r   [NS];
  pipe_t st_nxt [NS];
  logic  v_r    [NS];
  logic  adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hx_r <= 5'd2;
      ey_r <= 6'd4;
      ez_r <= 6'd4;
      et_r <= 6'd4;
    end else if (cfg_valid) begin
      unique case (cbn_pkg::cfg_reg_t'(cfg_index))
        cbn_pkg::REG_HALF_EXTENT_X: hx_r <= cfg_data[4:0];
        cbn_pkg::REG_EXTENT_Y:      ey_r <= cfg_data[5:0];
        cbn_pkg::REG_EXTENT_Z:      ez_r <= cfg_data[5:0];
        cbn_pkg::REG_EXTENT_T:      et_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  function automatic pipe_t div_step(input pipe_t p, input logic [16:0] d,
                                     input int unsigned b, input int unsigned sel);
    pipe_t       s;
    logic [23:0] sh;
    logic [5:0]  bit_m;
    s = p;
    sh = 24'(d) << b;
    bit_m = 6'd1 << b;
    if (24'(p.rem) >= sh) begin
      s.rem = 20'(24'(p.rem) - sh);
      case (sel)
        0:       s.ct = p.ct | bit_m;
        1:       s.cz = p.cz | bit_m;
        default: s.cy = p.cy | bit_m;
      endcase
    end
    return s;
  endfunction

  function automatic pipe_t stage_step(input int unsigned k, input pipe_t p);
    pipe_t      s;
    logic [6:0] len, cur, stp;
    logic       px;
    s = p;
    len = 7'd0;
    cur = 7'd0;
    if (k == cbn_pkg::S_D2) begin
      s.d2 = 17'(p.d1) * 17'(ez_r);
    end else if (k == cbn_pkg::S_HV) begin
      s.hv = 23'(p.d2) * 23'(et_r);
    end else if (k == cbn_pkg::S_SPLIT) begin
      s.oor = p.bad || (24'(p.site) >= {p.hv, 1'b0});
      s.par = 23'(p.site) >= p.hv;
      s.rem = s.par ? 20'(23'(p.site) - p.hv) : p.site;
      s.ct = '0;
      s.cz = '0;
      s.cy = '0;
    end else if (k >= cbn_pkg::S_T0 && k < cbn_pkg::S_Z0) begin
      s = div_step(p, p.d2, 4 - (k - cbn_pkg::S_T0), 0);
    end else if (k >= cbn_pkg::S_Z0 && k < cbn_pkg::S_Y0) begin
      s = div_step(p, 17'(p.d1), 4 - (k - cbn_pkg::S_Z0), 1);
    end else if (k >= cbn_pkg::S_Y0 && k < cbn_pkg::S_STEP) begin
      s = div_step(p, 17'(hx_r), 4 - (k - cbn_pkg::S_Y0), 2);
    end else if (k == cbn_pkg::S_STEP) begin
      px = p.par ^ p.cy[0] ^ p.cz[0] ^ p.ct[0];
      s.cx = {p.rem[4:0], px};
      case (cbn_pkg::dir_t'(p.dir))
        cbn_pkg::DIR_X: begin len = {1'b0, hx_r, 1'b0}; cur = {1'b0, s.cx}; end
        cbn_pkg::DIR_Y: begin len = {1'b0, ey_r};       cur = {1'b0, p.cy}; end
        cbn_pkg::DIR_Z: begin len = {1'b0, ez_r};       cur = {1'b0, p.cz}; end
        default:        begin len = {1'b0, et_r};       cur = {1'b0, p.ct}; end
      endcase
      if (p.fwd) stp = (cur + 7'd1 >= len) ? 7'd0 : cur + 7'd1;
      else       stp = (cur == 7'd0) ? len - 7'd1 : cur - 7'd1;
      case (cbn_pkg::dir_t'(p.dir))
        cbn_pkg::DIR_X: s.cx = stp[5:0];
        cbn_pkg::DIR_Y: s.cy = stp[5:0];
        cbn_pkg::DIR_Z: s.cz = stp[5:0];
        default:        s.ct = stp[5:0];
      endcase
      s.par = s.cx[0] ^ s.cy[0] ^ s.cz[0] ^ s.ct[0];
    end else if (k == cbn_pkg::S_M1) begin
      s.m = 25'(p.cz) + 25'(ez_r) * 25'(p.ct);
    end else if (k == cbn_pkg::S_M2) begin
      s.m = 25'(p.cy) + 25'(ey_r) * 25'(p.m[18:0]);
    end else if (k == cbn_pkg::S_M3) begin
      s.m = 25'(p.cx[5:1]) + 25'(hx_r) * 25'(p.m[19:0]);
    end else begin
      s.rem = p.oor ? 20'd0 : 20'(p.m + (p.par ? 25'(p.hv) : 25'd0));
    end
    return s;
  endfunction

  always_comb begin
    st_nxt[0]      = '0;
    st_nxt[0].site = in_data.site_index;
    st_nxt[0].dir  = in_data.direction;
    st_nxt[0].fwd  = in_data.forward;
    st_nxt[0].d1   = 11'(hx_r) * 11'(ey_r);
    st_nxt[0].bad  = (hx_r == 5'd0) || (ey_r == 6'd0) || (ez_r == 6'd0) || (et_r == 6'd0)
                  || (7'({hx_r, 1'b0}) > 7'(cbn_pkg::MAX_EXTENT))
                  || (7'(ey_r) > 7'(cbn_pkg::MAX_EXTENT))
                  || (7'(ez_r) > 7'(cbn_pkg::MAX_EXTENT))
                  || (7'(et_r) > 7'(cbn_pkg::MAX_EXTENT));
  end

  for (genvar g = 1; g < NS; g++) begin : g_stage
    always_comb begin
      st_nxt[g] = stage_step(g, st_r[g-1]);
    end
  end

  assign adv      = !v_r[NS-1] || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) v_r[i] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < NS; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NS; i++) st_r[i] <= st_nxt[i];
    end
  end

  assign out_valid              = v_r[NS-1];
  assign out_data.neighbor_site = st_r[NS-1].rem;
  assign out_data.out_of_range  = st_r[NS-1].oor;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  cbn_pkg::in_t                   in_data;
  logic                           out_valid;
  logic                           out_ready;
  cbn_pkg::out_t                  out_data;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [cbn_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [cbn_pkg::CFG_DATA_W-1:0] cfg_data;

  checkerboard_lattice_neighbor_index dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  localparam int unsigned DRAIN_CYCLES = 32;

  int unsigned geo_hx;
  int unsigned geo_ey;
  int unsigned geo_ez;
  int unsigned geo_et;

  cbn_pkg::out_t neighbor_q[$];
  int unsigned   fail_count;
  int unsigned   sent_count;
  int unsigned   flagged_count;
  int unsigned   checked_count;
  bit            quiet;
  int unsigned   stall_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("checkerboard_lattice_neighbor_index: mismatch");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit geometry_usable();
    return geo_hx != 0 && geo_ey != 0 && geo_ez != 0 && geo_et != 0 &&
           2 * geo_hx <= cbn_pkg::MAX_EXTENT && geo_ey <= cbn_pkg::MAX_EXTENT &&
           geo_ez <= cbn_pkg::MAX_EXTENT && geo_et <= cbn_pkg::MAX_EXTENT;
  endfunction

  function automatic cbn_pkg::out_t predict_neighbor(cbn_pkg::in_t d);
    cbn_pkg::out_t res;
    int unsigned   half_vol;
    int unsigned   site;
    int unsigned   par;
    int unsigned   off;
    int unsigned   c[4];
    int unsigned   len[4];
    int unsigned   lin;
    res.neighbor_site = '0;
    res.out_of_range  = 1'b1;
    if (!geometry_usable()) return res;
    half_vol = geo_hx * geo_ey * geo_ez * geo_et;
    site = 32'(d.site_index);
    if (site >= 2 * half_vol) return res;
    par = (site >= half_vol) ? 1 : 0;
    off = site - par * half_vol;
    c[0] = off % geo_hx; off = off / geo_hx;
    c[1] = off % geo_ey; off = off / geo_ey;
    c[2] = off % geo_ez; off = off / geo_ez;
    c[3] = off % geo_et;
    c[0] = 2 * c[0] + ((par + c[1] + c[2] + c[3]) & 1);
    len[0] = 2 * geo_hx;
    len[1] = geo_ey;
    len[2] = geo_ez;
    len[3] = geo_et;
    if (d.forward)
      c[d.direction] = (c[d.direction] + 1 >= len[d.direction]) ? 0 : c[d.direction] + 1;
    else
      c[d.direction] = (c[d.direction] == 0) ? len[d.direction] - 1 : c[d.direction] - 1;
    par = (c[0] + c[1] + c[2] + c[3]) & 1;
    lin = (c[0] >> 1) + geo_hx * (c[1] + geo_ey * (c[2] + geo_ez * c[3])) + par * half_vol;
    res.neighbor_site = lin[cbn_pkg::SITE_W-1:0];
    res.out_of_range  = 1'b0;
    return res;
  endfunction

  task automatic send_item(logic [cbn_pkg::SITE_W-1:0] site, cbn_pkg::dir_t dir, logic fwd);
    int unsigned  gap;
    cbn_pkg::in_t d;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    d.site_index = site;
    d.direction  = dir;
    d.forward    = fwd;
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    neighbor_q.push_back(predict_neighbor(d));
    sent_count++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (neighbor_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cbn_pkg::cfg_reg_t idx, logic [cbn_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      cbn_pkg::REG_HALF_EXTENT_X: geo_hx = 32'(value & 8'h1f);
      cbn_pkg::REG_EXTENT_Y:      geo_ey = 32'(value & 8'h3f);
      cbn_pkg::REG_EXTENT_Z:      geo_ez = 32'(value & 8'h3f);
      cbn_pkg::REG_EXTENT_T:      geo_et = 32'(value & 8'h3f);
      default: ;
    endcase
  endtask

  task automatic set_geometry(logic [7:0] hx, logic [7:0] ey, logic [7:0] ez, logic [7:0] et);
    drain();
    write_reg(cbn_pkg::REG_HALF_EXTENT_X, hx);
    write_reg(cbn_pkg::REG_EXTENT_Y, ey);
    write_reg(cbn_pkg::REG_EXTENT_Z, ez);
    write_reg(cbn_pkg::REG_EXTENT_T, et);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random(int unsigned count);
    int unsigned vol;
    int unsigned r;
    logic [cbn_pkg::SITE_W-1:0] site;
    vol = geometry_usable() ? 2 * geo_hx * geo_ey * geo_ez * geo_et : 0;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (vol != 0 && r < 80) site = 20'($urandom_range(0, vol - 1));
      else if (vol != 0 && r < 85) site = 20'(vol - 1);
      else if (vol != 0 && r < 90) site = 20'(vol);
      else site = 20'($urandom);
      send_item(site, cbn_pkg::dir_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_directed();
    for (int d = 0; d < 4; d++) begin
      for (int f = 0; f < 2; f++) begin
        send_item(20'd0, cbn_pkg::dir_t'(d), f[0]);
        send_item(20'd127, cbn_pkg::dir_t'(d), f[0]);
      end
    end
    send_item(20'd63, cbn_pkg::DIR_X, 1'b1);
    send_item(20'd64, cbn_pkg::DIR_X, 1'b0);
    send_item(20'd128, cbn_pkg::DIR_Y, 1'b1);
    send_item(20'hfffff, cbn_pkg::DIR_T, 1'b0);
    send_item(20'h80000, cbn_pkg::DIR_Z, 1'b1);
  endtask

  task automatic test_geometry_sweep();
    set_geometry(8'd16, 8'd32, 8'd32, 8'd32);
    send_random(150);
    set_geometry(8'd1, 8'd1, 8'd1, 8'd1);
    send_random(60);
    set_geometry(8'd3, 8'd5, 8'd7, 8'd2);
    send_random(100);
    set_geometry(8'd0, 8'd4, 8'd4, 8'd4);
    send_random(30);
    set_geometry(8'd17, 8'd4, 8'd4, 8'd4);
    send_random(30);
    set_geometry(8'd2, 8'd0, 8'd33, 8'd4);
    send_random(30);
    set_geometry(8'd4, 8'd4, 8'd4, 8'd33);
    send_random(30);
    set_geometry(8'he1, 8'hc3, 8'h45, 8'hff);
    send_random(60);
    set_geometry(8'd9, 8'd11, 8'd13, 8'd17);
    send_random(120);
  endtask

  task automatic test_backpressure_drain();
    set_geometry(8'($urandom_range(1, 16)), 8'($urandom_range(1, 32)),
                 8'($urandom_range(1, 32)), 8'($urandom_range(1, 32)));
    send_random(60);
    drain();
    quiet = 1'b1;
    send_random(80);
    quiet = 1'b0;
    send_random(60);
  endtask

  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready  <= 1'b1;
      stall_left <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
    end
  end

  always @(posedge clk) begin
    cbn_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (neighbor_q.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual %h", $time, out_data);
        fail_count++;
      end else begin
        want = neighbor_q.pop_front();
        checked_count++;
        if (want.out_of_range) flagged_count++;
        if (out_data.neighbor_site !== want.neighbor_site) begin
          $display("%0t: neighbor_site expected %0d actual %0d", $time,
                   want.neighbor_site, out_data.neighbor_site);
          fail_count++;
        end
        if (out_data.out_of_range !== want.out_of_range) begin
          $display("%0t: out_of_range expected %0b actual %0b", $time,
                   want.out_of_range, out_data.out_of_range);
          fail_count++;
        end
      end
    end
  end

  initial begin
    fail_count = 0;
    sent_count = 0;
    flagged_count = 0;
    checked_count = 0;
    quiet = 1'b0;
    geo_hx = 2;
    geo_ey = 4;
    geo_ez = 4;
    geo_et = 4;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= cbn_pkg::REG_HALF_EXTENT_X;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_geometry_sweep();
    test_backpressure_drain();
    drain();
    $display("sent %0d site transfers over default, extreme and unusable geometries", sent_count);
    $display("checked %0d neighbors, %0d of them flagged out of range", checked_count,
             flagged_count);
    if (fail_count == 0 && neighbor_q.size() == 0)
      $display("checkerboard_lattice_neighbor_index: match");
    else
      $display("checkerboard_lattice_neighbor_index: mismatch");
    $finish;
  end

endmodule
